### design/mcfe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cluster frame extractor.
// No dependencies; used by every module of the block.
package mcfe_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [31:0] EL_CLUSTER  = 32'h1F43B675;
    localparam logic [31:0] EL_TIMECODE = 32'h000000E7;
    localparam logic [31:0] EL_SIMPLE   = 32'h000000A3;
    localparam logic [31:0] EL_GROUP    = 32'h000000A0;
    localparam logic [31:0] EL_BLOCK    = 32'h000000A1;

    localparam logic [15:0] TRACK_RESET = 16'd1;
    localparam logic [31:0] SCALE_RESET = 32'd1000000;

    localparam logic CFG_TRACK = 1'b0;
    localparam logic CFG_SCALE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_last;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] payload_length;
        logic [63:0] time_us;
        logic        keyframe;
        logic        frame_last;
        logic        malformed;
    } out_item_t;

    // Result job from the parser to the time unit: frame header, payload byte or fault
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] payload_length;
        logic [63:0] ticks;
        logic        keyframe;
        logic        frame_last;
        logic        malformed;
    } job_t;

    function automatic logic [3:0] vint_len(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 1; i--)
        begin
            if (b[i] && n == 4'd8 && ((4'd8 - 4'(i)) < n))
                n = 4'd8 - 4'(i);
        end
        if (b[7])
            n = 4'd1;
        return n;
    endfunction

    // Mask of the data bits below the length marker
    function automatic logic [7:0] vint_mask(input logic [3:0] len);
        return 8'(8'hFF >> len);
    endfunction

endpackage

### design/mcfe_parser.sv
`timescale 1ns / 1ps
// Front part: byte-wise EBML parser producing result jobs.
// Depends on mcfe_pkg.
module mcfe_parser #(
    parameter int SIZE_BITS = mcfe_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  mcfe_pkg::in_item_t  in_item,
    input  logic [15:0]         sel_track,
    output logic                job_valid,
    output mcfe_pkg::job_t      job
);

    typedef enum logic [3:0] {
        PH_SEG_HDR, PH_SEG_SKIP, PH_DEAD, PH_CL_HDR, PH_CL_SKIP, PH_CL_TIME,
        PH_CL_REST, PH_GRP_HDR, PH_GRP_SKIP, PH_GRP_REST, PH_BLK_TRACK,
        PH_BLK_REL_HI, PH_BLK_REL_LO, PH_BLK_FLAGS, PH_BLK_PAYLOAD, PH_BLK_SKIP
    } phase_t;

    localparam logic [63:0] SIZE_MAX = 64'((65'd1 << SIZE_BITS) - 65'd1);

    phase_t      phase_reg, phase_next;
    logic [2:0]  vleft_reg, vleft_next;
    logic [63:0] vval_reg, vval_next;
    logic [31:0] eid_reg, eid_next;
    logic [63:0] cl_reg, cl_next, grp_reg, grp_next, el_reg, el_next;
    logic [63:0] ctime_reg, ctime_next;
    logic [15:0] rel_reg, rel_next;
    logic        stage_reg, stage_next;
    logic [3:0]  take_reg, take_next;
    logic        ingrp_reg, ingrp_next;
    logic        jv_next;
    mcfe_pkg::job_t job_next;

    function automatic logic [63:0] dec(input logic [63:0] v);
        return (v != 64'd0) ? v - 64'd1 : 64'd0;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  len;
        logic [63:0] avail;
        logic        bnd;
        logic        hdr_go;
        logic [1:0]  hr;
        logic [63:0] prior_left;
        logic        idle;

        b = in_item.data_byte;
        phase_next = phase_reg; vleft_next = vleft_reg; vval_next = vval_reg;
        eid_next = eid_reg; cl_next = cl_reg; grp_next = grp_reg; el_next = el_reg;
        ctime_next = ctime_reg; rel_next = rel_reg; stage_next = stage_reg;
        take_next = take_reg; ingrp_next = ingrp_reg;
        jv_next = 1'b0;
        job_next = '0;
        len = mcfe_pkg::vint_len(b);
        avail = 64'd0; bnd = 1'b0; hdr_go = 1'b0; hr = 2'd0; prior_left = 64'd0;
        idle = 1'b0;

        if (in_fire)
        begin
            // pick header parse context
            unique case (phase_reg)
                PH_SEG_HDR: begin hdr_go = 1'b1; bnd = 1'b0; end
                PH_CL_HDR:  begin hdr_go = 1'b1; bnd = 1'b1; avail = cl_reg; end
                PH_GRP_HDR: begin hdr_go = 1'b1; bnd = 1'b1; avail = grp_reg; end
                default:    hdr_go = 1'b0;
            endcase
            // hr: 0 pending, 1 done, 2 fault
            if (hdr_go)
            begin
                if (vleft_reg == 3'd0)
                begin
                    if (b == 8'd0 || (bnd && {60'd0, len} > avail))
                    begin
                        stage_next = 1'b0; hr = 2'd2;
                    end
                    else
                    begin
                        vval_next = stage_reg ? {56'd0, b & mcfe_pkg::vint_mask(len)}
                                              : {56'd0, b};
                        vleft_next = 3'(len - 4'd1);
                    end
                end
                else
                begin
                    vval_next = {vval_reg[55:0], b};
                    vleft_next = vleft_reg - 3'd1;
                end
                if (hr == 2'd0 && vleft_next == 3'd0)
                begin
                    if (!stage_reg)
                    begin
                        eid_next = vval_next[31:0];
                        stage_next = 1'b1;
                        if (bnd && avail <= 64'd1)
                        begin
                            stage_next = 1'b0; hr = 2'd2;
                        end
                    end
                    else
                    begin
                        stage_next = 1'b0;
                        if (vval_next > SIZE_MAX || (bnd && vval_next > avail - 64'd1))
                            hr = 2'd2;
                        else
                        begin
                            el_next = vval_next; hr = 2'd1;
                        end
                    end
                end
            end

            priority case (phase_reg)
                PH_SEG_HDR:
                begin
                    if (hr == 2'd2)
                    begin
                        jv_next = 1'b1; job_next.malformed = 1'b1; phase_next = PH_DEAD;
                    end
                    else if (hr == 2'd1)
                    begin
                        if (eid_next == mcfe_pkg::EL_CLUSTER)
                        begin
                            cl_next = el_next; ctime_next = 64'd0; phase_next = PH_CL_HDR;
                        end
                        else
                            phase_next = PH_SEG_SKIP;
                    end
                end
                PH_SEG_SKIP: el_next = dec(el_reg);
                PH_DEAD: ;
                default:
                begin
                    cl_next = dec(cl_reg);
                    unique case (phase_reg)
                        PH_CL_HDR:
                        begin
                            if (hr == 2'd2)
                            begin
                                jv_next = 1'b1; job_next.malformed = 1'b1;
                                phase_next = PH_CL_REST;
                            end
                            else if (hr == 2'd1)
                            begin
                                if (eid_next == mcfe_pkg::EL_TIMECODE)
                                begin
                                    ctime_next = 64'd0; take_next = 4'd8;
                                    phase_next = PH_CL_TIME;
                                end
                                else if (eid_next == mcfe_pkg::EL_SIMPLE)
                                begin
                                    ingrp_next = 1'b0; vleft_next = 3'd0; vval_next = 64'd0;
                                    phase_next = (el_next < 64'd4) ? PH_BLK_SKIP : PH_BLK_TRACK;
                                end
                                else if (eid_next == mcfe_pkg::EL_GROUP)
                                begin
                                    grp_next = el_next; phase_next = PH_GRP_HDR;
                                end
                                else
                                    phase_next = PH_CL_SKIP;
                            end
                        end
                        PH_CL_SKIP: el_next = dec(el_reg);
                        PH_CL_TIME:
                        begin
                            el_next = dec(el_reg);
                            if (take_reg != 4'd0)
                            begin
                                ctime_next = {ctime_reg[55:0], b};
                                take_next = take_reg - 4'd1;
                            end
                        end
                        PH_CL_REST: ;
                        PH_GRP_HDR:
                        begin
                            grp_next = dec(grp_reg);
                            if (hr == 2'd2)
                            begin
                                vleft_next = 3'd0; phase_next = PH_GRP_REST;
                            end
                            else if (hr == 2'd1)
                            begin
                                if (eid_next == mcfe_pkg::EL_BLOCK)
                                begin
                                    ingrp_next = 1'b1; vleft_next = 3'd0; vval_next = 64'd0;
                                    phase_next = (el_next < 64'd4) ? PH_BLK_SKIP : PH_BLK_TRACK;
                                end
                                else
                                    phase_next = PH_GRP_SKIP;
                            end
                        end
                        PH_GRP_SKIP:
                        begin
                            grp_next = dec(grp_reg); el_next = dec(el_reg);
                        end
                        PH_GRP_REST: grp_next = dec(grp_reg);
                        default:
                        begin
                            if (ingrp_reg)
                                grp_next = dec(grp_reg);
                            prior_left = el_reg;
                            el_next = dec(el_reg);
                            unique case (phase_reg)
                                PH_BLK_TRACK:
                                begin
                                    if (vleft_reg == 3'd0 &&
                                        (b == 8'd0 || {60'd0, len} > prior_left))
                                        phase_next = PH_BLK_SKIP;
                                    else
                                    begin
                                        if (vleft_reg == 3'd0)
                                        begin
                                            vval_next = {56'd0, b & mcfe_pkg::vint_mask(len)};
                                            vleft_next = 3'(len - 4'd1);
                                        end
                                        else
                                        begin
                                            vval_next = {vval_reg[55:0], b};
                                            vleft_next = vleft_reg - 3'd1;
                                        end
                                        if (vleft_next == 3'd0)
                                        begin
                                            if (sel_track == 16'd0 ||
                                                vval_next != {48'd0, sel_track} ||
                                                el_next < 64'd3)
                                                phase_next = PH_BLK_SKIP;
                                            else
                                                phase_next = PH_BLK_REL_HI;
                                        end
                                    end
                                end
                                PH_BLK_REL_HI:
                                begin
                                    rel_next = {b, 8'd0}; phase_next = PH_BLK_REL_LO;
                                end
                                PH_BLK_REL_LO:
                                begin
                                    rel_next = {rel_reg[15:8], b}; phase_next = PH_BLK_FLAGS;
                                end
                                PH_BLK_FLAGS:
                                begin
                                    if (b[2:1] != 2'd0)
                                        phase_next = PH_BLK_SKIP;
                                    else
                                    begin
                                        jv_next = 1'b1;
                                        job_next.payload_length = el_next[31:0];
                                        job_next.ticks = ctime_reg + {{48{rel_reg[15]}}, rel_reg};
                                        job_next.keyframe = b[7];
                                        job_next.frame_last = (el_next == 64'd0);
                                        phase_next = PH_BLK_PAYLOAD;
                                    end
                                end
                                PH_BLK_PAYLOAD:
                                begin
                                    jv_next = 1'b1;
                                    job_next.kind = 1'b1;
                                    job_next.payload_byte = b;
                                    job_next.frame_last = (el_next == 64'd0);
                                end
                                default: ;
                            endcase
                        end
                    endcase
                end
            endcase

            // settle: unrolled, each level closes at most once
            idle = (vleft_next == 3'd0 && !stage_next);
            if (phase_next >= PH_BLK_TRACK && el_next == 64'd0)
                phase_next = ingrp_next ? PH_GRP_REST : PH_CL_HDR;
            if ((phase_next == PH_CL_SKIP || phase_next == PH_CL_TIME) && el_next == 64'd0)
                phase_next = PH_CL_HDR;
            if (phase_next == PH_GRP_SKIP && el_next == 64'd0)
                phase_next = PH_GRP_HDR;
            if (((phase_next == PH_GRP_HDR && idle) || phase_next == PH_GRP_REST) &&
                grp_next == 64'd0)
                phase_next = PH_CL_HDR;
            if (((phase_next == PH_CL_HDR && idle) || phase_next == PH_CL_REST) &&
                cl_next == 64'd0)
                phase_next = PH_SEG_HDR;
            if (phase_next == PH_SEG_SKIP && el_next == 64'd0)
                phase_next = PH_SEG_HDR;

            if (in_item.segment_last)
            begin
                phase_next = PH_SEG_HDR; vleft_next = 3'd0; vval_next = 64'd0;
                eid_next = 32'd0; cl_next = 64'd0; grp_next = 64'd0; el_next = 64'd0;
                ctime_next = 64'd0; rel_next = 16'd0; stage_next = 1'b0;
                take_next = 4'd0; ingrp_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEG_HDR; vleft_reg <= '0; vval_reg <= '0; eid_reg <= '0;
            cl_reg <= '0; grp_reg <= '0; el_reg <= '0; ctime_reg <= '0; rel_reg <= '0;
            stage_reg <= 1'b0; take_reg <= '0; ingrp_reg <= 1'b0; job_valid <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; vleft_reg <= vleft_next; vval_reg <= vval_next;
            eid_reg <= eid_next; cl_reg <= cl_next; grp_reg <= grp_next;
            el_reg <= el_next; ctime_reg <= ctime_next; rel_reg <= rel_next;
            stage_reg <= stage_next; take_reg <= take_next; ingrp_reg <= ingrp_next;
            job_valid <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job <= job_next;
    end

`ifndef NO_ASSERTIONS
    a_job_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> $past(in_fire))
        else $error("job without an accepted byte");
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job.kind) |-> !job.malformed)
        else $error("payload job flagged malformed");
    a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DEAD) |=> !job_valid)
        else $error("result after segment fault");
`endif

endmodule

### design/mcfe_time.sv
`timescale 1ns / 1ps
// Back part: scales tick counts to microseconds over a short pipeline.
// Depends on mcfe_pkg.
module mcfe_time (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  mcfe_pkg::job_t     job,
    input  logic [31:0]        scale,
    output logic               res_valid,
    output mcfe_pkg::out_item_t res
);

    // ceil(2^73/1000): exact quotient for every magnitude up to 2^63
    localparam logic [63:0] RECIP = 64'd9444732965739290428;

    // stage 1: two 32x32 partial products of ticks*scale
    logic        s1_v_reg;
    mcfe_pkg::job_t s1_job_reg;
    logic [63:0] p_lo_reg, p_hi_reg;
    // stage 2: product and magnitude
    logic        s2_v_reg;
    mcfe_pkg::job_t s2_job_reg;
    logic [63:0] mag_reg;
    logic        neg_reg;
    // stage 3: partial products of mag*RECIP
    logic        s3_v_reg;
    mcfe_pkg::job_t s3_job_reg;
    logic [63:0] q_ll_reg, q_lh_reg, q_hl_reg, q_hh_reg;
    logic [63:0] mag3_reg;
    logic        neg3_reg;

    logic [63:0] prod;
    logic [127:0] qfull;
    logic [63:0] quot;

    assign prod = p_lo_reg + {p_hi_reg[31:0], 32'd0};
    assign qfull = {64'd0, q_ll_reg} + {32'd0, q_lh_reg, 32'd0}
                 + {32'd0, q_hl_reg, 32'd0} + {q_hh_reg, 64'd0};
    assign quot = 64'(qfull >> 73);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0; s2_v_reg <= 1'b0; s3_v_reg <= 1'b0; res_valid <= 1'b0;
        end
        else
        begin
            s1_v_reg <= job_valid; s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg; res_valid <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_job_reg <= job;
        p_lo_reg <= job.ticks[31:0] * scale;
        p_hi_reg <= 64'(job.ticks[63:32] * scale);
        s2_job_reg <= s1_job_reg;
        neg_reg <= prod[63];
        mag_reg <= prod[63] ? 64'd0 - prod : prod;
        s3_job_reg <= s2_job_reg;
        neg3_reg <= neg_reg;
        mag3_reg <= mag_reg;
        q_ll_reg <= mag_reg[31:0] * RECIP[31:0];
        q_lh_reg <= mag_reg[31:0] * RECIP[63:32];
        q_hl_reg <= mag_reg[63:32] * RECIP[31:0];
        q_hh_reg <= mag_reg[63:32] * RECIP[63:32];
        res.kind <= s3_job_reg.kind;
        res.payload_byte <= s3_job_reg.payload_byte;
        res.payload_length <= s3_job_reg.payload_length;
        res.keyframe <= s3_job_reg.keyframe;
        res.frame_last <= s3_job_reg.frame_last;
        res.malformed <= s3_job_reg.malformed;
        if (s3_job_reg.kind || s3_job_reg.malformed)
            res.time_us <= 64'd0;
        else
            res.time_us <= neg3_reg ? 64'd0 - quot : quot;
    end

`ifndef NO_ASSERTIONS
    a_pipe_len: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> ##4 res_valid)
        else $error("time pipeline lost a job");
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |=> (res_valid))
        else $error("pipeline valid broken");
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> (quot <= mag3_reg))
        else $error("quotient above dividend");
`endif

endmodule

### design/mcfe_queue.sv
`timescale 1ns / 1ps
// Result queue between the pipeline and the consumer.
// Depends on mcfe_pkg.
module mcfe_queue #(
    parameter int DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  mcfe_pkg::out_item_t wdata,
    input  logic                rd,
    output mcfe_pkg::out_item_t rdata,
    output logic                empty,
    output logic [$clog2(DEPTH):0] count
);

    localparam int AW = $clog2(DEPTH);

    mcfe_pkg::out_item_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= AW'((32'(wp_reg) + 1) % DEPTH);
            if (rd && !empty)
                rp_reg <= AW'((32'(rp_reg) + 1) % DEPTH);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (cnt_reg < (AW+1)'(DEPTH) || rd))
        else $error("result queue overflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!wr && !rd) |=> $stable(cnt_reg))
        else $error("count moved without a transaction");
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !wr) |=> empty)
        else $error("queue filled without a write");
`endif

endmodule

### design/matroska_cluster_frame_extractor.sv
`timescale 1ns / 1ps
// Top level of the cluster frame extractor: config, parser, time unit, queue.
// Depends on mcfe_pkg, mcfe_parser, mcfe_time, mcfe_queue.
//
// Takes one byte per clock while full is low and gives at most one result per byte;
// a result leaves the front parser in the cycle after its byte and passes a
// four-stage time-scaling pipeline (two rounds of 32x32 partial products) before
// it enters an eight-entry result queue. full rises once three results wait in
// the queue, which leaves room for the five results that may be in the pipeline
// and the byte accepted in the same cycle, and keeps one byte per clock whenever
// the consumer pops at that rate.
module matroska_cluster_frame_extractor #(
    parameter int SIZE_BITS = mcfe_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mcfe_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output mcfe_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int QDEPTH = 8;
    localparam int INFLIGHT = 6;

    logic [15:0] track_reg;
    logic [31:0] scale_reg;
    logic        in_fire;
    logic        job_valid, res_valid;
    mcfe_pkg::job_t job;
    mcfe_pkg::out_item_t res;
    logic [$clog2(QDEPTH):0] count;

    assign cfg_ready = 1'b1;
    assign in_fire = push && !full;
    // room for every result that may still arrive
    assign full = (32'(count) > QDEPTH - INFLIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= mcfe_pkg::TRACK_RESET;
            scale_reg <= mcfe_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mcfe_pkg::CFG_TRACK: track_reg <= cfg_data[15:0];
                mcfe_pkg::CFG_SCALE: scale_reg <= cfg_data;
            endcase
        end
    end

    mcfe_parser #(.SIZE_BITS(SIZE_BITS)) u_parser (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_item(in_item),
        .sel_track(track_reg), .job_valid(job_valid), .job(job)
    );

    mcfe_time u_time (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .scale(scale_reg), .res_valid(res_valid), .res(res)
    );

    mcfe_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(res_valid), .wdata(res), .rd(pop),
        .rdata(out_item), .empty(empty), .count(count)
    );

endmodule

### sim/tb_matroska_cluster_frame_extractor.sv
`timescale 1ns / 1ps
// Self-checking bench for the cluster frame extractor: generated segment byte streams,
// a cycle-free frame predictor and an in-order check of every result.
// Depends on mcfe_pkg and matroska_cluster_frame_extractor.
module tb_matroska_cluster_frame_extractor;

    typedef bit [7:0] bytes_t[$];

    typedef enum logic [3:0] {
        P_SEG_HDR, P_SEG_SKIP, P_DEAD, P_CL_HDR, P_CL_SKIP, P_CL_TIME, P_CL_REST,
        P_GRP_HDR, P_GRP_SKIP, P_GRP_REST, P_BLK_TRACK, P_BLK_REL_HI, P_BLK_REL_LO,
        P_BLK_FLAGS, P_BLK_PAYLOAD, P_BLK_SKIP
    } parse_phase_e;

    localparam logic [63:0] SIZE_LIMIT = (64'd1 << mcfe_pkg::SIZE_BITS_DEF) - 64'd1;
    localparam logic [31:0] EL_INFO = 32'h1549A966;
    localparam logic [31:0] EL_VOID = 32'h000000EC;
    localparam int STALL_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    mcfe_pkg::in_item_t in_item;
    logic empty;
    logic pop;
    mcfe_pkg::out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [31:0] cfg_data;

    matroska_cluster_frame_extractor u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mcfe_pkg::in_item_t  byte_feed[$];
    mcfe_pkg::out_item_t frame_expect[$];
    int send_idle, recv_idle, phase_no, errors, idle_cycles;
    int n_bytes, n_headers, n_payload, n_malformed;
    int stall_left;
    bit stall_done;

    // predictor copy of the registers and parse state
    logic [15:0] track_sel;
    logic [31:0] tick_ns;
    parse_phase_e ph;
    int          vint_left;
    logic [63:0] vint_acc;
    logic [31:0] elem_id;
    logic [63:0] cl_left, grp_left, el_left, cl_time;
    logic [15:0] rel_time;
    bit          id_done;
    int          time_take;
    bit          grouped;

    function automatic logic [63:0] sat_dec(logic [63:0] v);
        return (v != 0) ? v - 64'd1 : 64'd0;
    endfunction

    function automatic int marker_len(logic [7:0] b);
        int n;
        n = 1;
        while (!b[8 - n] && n < 8)
            n++;
        return n;
    endfunction

    task automatic clear_parse();
        ph = P_SEG_HDR; vint_left = 0; vint_acc = 0; elem_id = 0;
        cl_left = 0; grp_left = 0; el_left = 0; cl_time = 0; rel_time = 0;
        id_done = 0; time_take = 0; grouped = 0;
    endtask

    // one header byte; 1 when the size is complete, -1 on a fault
    function automatic int header_byte(logic [7:0] b, logic [63:0] avail, bit bounded);
        int len;
        logic [7:0] mask;
        if (vint_left == 0)
        begin
            if (b == 0)
            begin
                id_done = 0;
                return -1;
            end
            len = marker_len(b);
            if (bounded && 64'(len) > avail)
            begin
                id_done = 0;
                return -1;
            end
            mask = (8'h80 >> (len - 1)) - 8'd1;
            vint_acc = id_done ? 64'(b & mask) : 64'(b);
            vint_left = len - 1;
        end
        else
        begin
            vint_acc = (vint_acc << 8) | 64'(b);
            vint_left--;
        end
        if (vint_left != 0)
            return 0;
        if (!id_done)
        begin
            elem_id = vint_acc[31:0];
            id_done = 1;
            if (bounded && avail <= 1)
            begin
                id_done = 0;
                return -1;
            end
            return 0;
        end
        id_done = 0;
        if (vint_acc > SIZE_LIMIT)
            return -1;
        if (bounded && vint_acc > avail - 64'd1)
            return -1;
        el_left = vint_acc;
        return 1;
    endfunction

    task automatic open_block(bit in_grp);
        grouped = in_grp;
        vint_left = 0;
        vint_acc = 0;
        ph = (el_left < 4) ? P_BLK_SKIP : P_BLK_TRACK;
    endtask

    function automatic logic [63:0] frame_us();
        logic [63:0] prod;
        prod = (cl_time + {{48{rel_time[15]}}, rel_time}) * {32'd0, tick_ns};
        if (prod[63])
            return 64'd0 - ((64'd0 - prod) / 64'd1000);
        return prod / 64'd1000;
    endfunction

    task automatic settle();
        bit idle;
        forever
        begin
            idle = (vint_left == 0 && !id_done);
            if (ph >= P_BLK_TRACK && el_left == 0)
                ph = grouped ? P_GRP_REST : P_CL_HDR;
            else if ((ph == P_CL_SKIP || ph == P_CL_TIME) && el_left == 0)
                ph = P_CL_HDR;
            else if (ph == P_GRP_SKIP && el_left == 0)
                ph = P_GRP_HDR;
            else if (((ph == P_GRP_HDR && idle) || ph == P_GRP_REST) && grp_left == 0)
                ph = P_CL_HDR;
            else if (((ph == P_CL_HDR && idle) || ph == P_CL_REST) && cl_left == 0)
                ph = P_SEG_HDR;
            else if (ph == P_SEG_SKIP && el_left == 0)
                ph = P_SEG_HDR;
            else
                break;
        end
    endtask

    task automatic parse_byte(mcfe_pkg::in_item_t it);
        logic [7:0] b;
        logic [63:0] prior;
        mcfe_pkg::out_item_t res;
        bit got;
        int r, len;
        b = it.data_byte;
        res = '0;
        got = 0;
        if (ph == P_SEG_HDR)
        begin
            r = header_byte(b, 0, 0);
            if (r < 0)
            begin
                res.malformed = 1; got = 1; ph = P_DEAD;
            end
            else if (r > 0)
            begin
                if (elem_id == mcfe_pkg::EL_CLUSTER)
                begin
                    cl_left = el_left; cl_time = 0; ph = P_CL_HDR;
                end
                else
                    ph = P_SEG_SKIP;
            end
        end
        else if (ph == P_SEG_SKIP)
            el_left = sat_dec(el_left);
        else if (ph != P_DEAD)
        begin
            prior = cl_left;
            cl_left = sat_dec(cl_left);
            case (ph)
                P_CL_HDR:
                begin
                    r = header_byte(b, prior, 1);
                    if (r < 0)
                    begin
                        res.malformed = 1; got = 1; ph = P_CL_REST;
                    end
                    else if (r > 0)
                    begin
                        if (elem_id == mcfe_pkg::EL_TIMECODE)
                        begin
                            cl_time = 0; time_take = 8; ph = P_CL_TIME;
                        end
                        else if (elem_id == mcfe_pkg::EL_SIMPLE)
                            open_block(0);
                        else if (elem_id == mcfe_pkg::EL_GROUP)
                        begin
                            grp_left = el_left; ph = P_GRP_HDR;
                        end
                        else
                            ph = P_CL_SKIP;
                    end
                end
                P_CL_SKIP: el_left = sat_dec(el_left);
                P_CL_TIME:
                begin
                    el_left = sat_dec(el_left);
                    if (time_take != 0)
                    begin
                        cl_time = (cl_time << 8) | 64'(b);
                        time_take--;
                    end
                end
                P_CL_REST: ;
                P_GRP_HDR:
                begin
                    prior = grp_left;
                    grp_left = sat_dec(grp_left);
                    r = header_byte(b, prior, 1);
                    if (r < 0)
                    begin
                        vint_left = 0; ph = P_GRP_REST;
                    end
                    else if (r > 0)
                    begin
                        if (elem_id == mcfe_pkg::EL_BLOCK)
                            open_block(1);
                        else
                            ph = P_GRP_SKIP;
                    end
                end
                P_GRP_SKIP:
                begin
                    grp_left = sat_dec(grp_left);
                    el_left = sat_dec(el_left);
                end
                P_GRP_REST: grp_left = sat_dec(grp_left);
                default:
                begin
                    if (grouped)
                        grp_left = sat_dec(grp_left);
                    prior = el_left;
                    el_left = sat_dec(el_left);
                    if (ph == P_BLK_TRACK)
                    begin
                        if (vint_left == 0)
                        begin
                            len = marker_len(b);
                            if (b == 0 || 64'(len) > prior)
                                ph = P_BLK_SKIP;
                            else
                            begin
                                vint_acc = 64'(b & ((8'h80 >> (len - 1)) - 8'd1));
                                vint_left = len - 1;
                            end
                        end
                        else
                        begin
                            vint_acc = (vint_acc << 8) | 64'(b);
                            vint_left--;
                        end
                        if (ph == P_BLK_TRACK && vint_left == 0)
                        begin
                            if (track_sel == 0 || vint_acc != 64'(track_sel) || el_left < 3)
                                ph = P_BLK_SKIP;
                            else
                                ph = P_BLK_REL_HI;
                        end
                    end
                    else if (ph == P_BLK_REL_HI)
                    begin
                        rel_time = {b, 8'd0}; ph = P_BLK_REL_LO;
                    end
                    else if (ph == P_BLK_REL_LO)
                    begin
                        rel_time[7:0] = b; ph = P_BLK_FLAGS;
                    end
                    else if (ph == P_BLK_FLAGS)
                    begin
                        if (b[2:1] != 0)
                            ph = P_BLK_SKIP;
                        else
                        begin
                            res.payload_length = el_left[31:0];
                            res.time_us = frame_us();
                            res.keyframe = b[7];
                            res.frame_last = (el_left == 0);
                            got = 1;
                            ph = P_BLK_PAYLOAD;
                        end
                    end
                    else if (ph == P_BLK_PAYLOAD)
                    begin
                        res.kind = 1;
                        res.payload_byte = b;
                        res.frame_last = (el_left == 0);
                        got = 1;
                    end
                end
            endcase
        end
        settle();
        if (it.segment_last)
            clear_parse();
        if (got)
            frame_expect.push_back(res);
    endtask

    // ---------------- stream generation ----------------
    function automatic bytes_t size_vint(logic [63:0] v, int min_len);
        bytes_t q;
        int len;
        len = 1;
        while (len < 8 && v >= (64'd1 << (7 * len)))
            len++;
        if (len < min_len)
            len = min_len;
        q.push_back((8'h80 >> (len - 1)) | 8'(v >> (8 * (len - 1))));
        for (int i = len - 2; i >= 0; i--)
            q.push_back(8'(v >> (8 * i)));
        return q;
    endfunction

    function automatic bytes_t element(logic [31:0] id, bytes_t body);
        bytes_t q;
        for (int i = 3; i >= 0; i--)
        begin
            if (id >> (8 * i) != 0)
                q.push_back(8'(id >> (8 * i)));
        end
        q = {q, size_vint(body.size(), ($urandom_range(7) == 0) ? $urandom_range(1, 8) : 1)};
        return {q, body};
    endfunction

    function automatic bytes_t random_bytes(int n);
        bytes_t q;
        repeat (n)
            q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic bytes_t block_body();
        bytes_t q;
        logic [7:0] flags;
        if ($urandom_range(9) == 0)
            return random_bytes($urandom_range(0, 3));
        q = size_vint(($urandom_range(4) == 0) ? 64'($urandom_range(1, 65535)) : 64'(track_sel),
                      1);
        q = {q, random_bytes(2)};
        flags = 8'($urandom);
        if ($urandom_range(6) != 0)
            flags[2:1] = 0;
        q.push_back(flags);
        return {q, random_bytes(($urandom_range(9) == 0) ? $urandom_range(0, 40)
                                                         : $urandom_range(0, 6))};
    endfunction

    function automatic bytes_t cluster_body();
        bytes_t q, g;
        int pick;
        q = element(mcfe_pkg::EL_TIMECODE,
                    random_bytes(($urandom_range(9) == 0) ? 9 : $urandom_range(1, 4)));
        repeat ($urandom_range(1, 4))
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                q = {q, element(mcfe_pkg::EL_SIMPLE, block_body())};
            else if (pick < 75)
            begin
                g = element(mcfe_pkg::EL_BLOCK, block_body());
                if ($urandom_range(1))
                    g = {element(EL_VOID, random_bytes($urandom_range(0, 2))), g};
                if ($urandom_range(1))
                    g = {g, element(mcfe_pkg::EL_BLOCK, block_body())};
                if ($urandom_range(7) == 0)
                    g = {g, 8'h00};
                q = {q, element(mcfe_pkg::EL_GROUP, g)};
            end
            else if (pick < 90)
                q = {q, element(EL_VOID, random_bytes($urandom_range(0, 3)))};
            else
                q = {q, 8'h00, random_bytes($urandom_range(1, 3))};
        end
        return q;
    endfunction

    task automatic queue_segment(bytes_t seg);
        mcfe_pkg::in_item_t it;
        foreach (seg[i])
        begin
            it.data_byte = seg[i];
            it.segment_last = (i == seg.size() - 1);
            byte_feed.push_back(it);
        end
    endtask

    task automatic random_segment();
        bytes_t seg;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            seg = random_bytes($urandom_range(3, 15));
        else
        begin
            if ($urandom_range(3) == 0)
                seg = element(EL_INFO, random_bytes($urandom_range(0, 3)));
            repeat ($urandom_range(1, 3))
                seg = {seg, element(mcfe_pkg::EL_CLUSTER, cluster_body())};
            if (pick < 18)
                seg = seg[0:$urandom_range(0, seg.size() - 1)];
        end
        queue_segment(seg);
    endtask

    task automatic wait_drained();
        while (byte_feed.size() != 0 || frame_expect.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == mcfe_pkg::CFG_TRACK)
            track_sel = val[15:0];
        else
            tick_ns = val;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver and receiver: change inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                push <= 1;
                in_item <= byte_feed[0];
            end
            else
                push <= 0;
            if (phase_no == 2 && !stall_done && byte_feed.size() != 0)
            begin
                stall_left <= 400;
                stall_done <= 1;
                pop <= 0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                pop <= 0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor: accept transactions on the rising edge
    always @(posedge clk)
    begin
        bit moved;
        moved = 0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                parse_byte(in_item);
                void'(byte_feed.pop_front());
                n_bytes++;
                moved = 1;
            end
            if (cfg_valid && cfg_ready)
                moved = 1;
            if (pop && !empty)
            begin
                moved = 1;
                if (frame_expect.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $time, out_item);
                    errors++;
                end
                else
                begin
                    mcfe_pkg::out_item_t want;
                    want = frame_expect.pop_front();
                    check_field("kind", want.kind, out_item.kind);
                    check_field("payload_byte", want.payload_byte, out_item.payload_byte);
                    check_field("payload_length", want.payload_length,
                                out_item.payload_length);
                    check_field("time_us", want.time_us, out_item.time_us);
                    check_field("keyframe", want.keyframe, out_item.keyframe);
                    check_field("frame_last", want.frame_last, out_item.frame_last);
                    check_field("malformed", want.malformed, out_item.malformed);
                    if (want.malformed)
                        n_malformed++;
                    else if (want.kind)
                        n_payload++;
                    else
                        n_headers++;
                end
            end
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 0;
        push = 0;
        pop = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = mcfe_pkg::CFG_TRACK;
        cfg_data = '0;
        send_idle = 30;
        recv_idle = 51;
        phase_no = 0;
        errors = 0;
        idle_cycles = 0;
        stall_left = 0;
        stall_done = 0;
        track_sel = mcfe_pkg::TRACK_RESET;
        tick_ns = mcfe_pkg::SCALE_RESET;
        clear_parse();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: keyframe with negative relative time, empty frame, malformed
        // child, then a malformed segment-level id and a truncated segment
        queue_segment({8'h1F, 8'h43, 8'hB6, 8'h75, 8'h93,
                       8'hE7, 8'h81, 8'hFF,
                       8'hA3, 8'h86, 8'h81, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h00,
                       8'hA3, 8'h84, 8'h81, 8'h7F, 8'hFF, 8'h00,
                       8'h00});
        queue_segment({8'h00, 8'hFF});
        queue_segment({8'h1F, 8'h43, 8'hB6, 8'h75, 8'h01});
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(mcfe_pkg::CFG_TRACK, 32'd65535);
                    write_reg(mcfe_pkg::CFG_SCALE, 32'd1);
                end
                1:
                begin
                    send_idle = 51;
                    recv_idle = 30;
                    write_reg(mcfe_pkg::CFG_TRACK, 32'd1);
                    write_reg(mcfe_pkg::CFG_SCALE, 32'hFFFFFFFF);
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_reg(mcfe_pkg::CFG_TRACK, 32'($urandom_range(1, 300)));
                    write_reg(mcfe_pkg::CFG_SCALE, $urandom);
                end
            endcase
            phase_no = p;
            while (byte_feed.size() < 250)
                random_segment();
            wait_drained();
        end

        $display("Streamed %0d segment bytes over three register settings and idle mixes:",
                 n_bytes);
        $display("  %0d frame headers, %0d payload bytes, %0d malformed flags checked",
                 n_headers, n_payload, n_malformed);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
